>>> rtl/tpt_pkg.sv
// ============================================================================
// Team presence tracker package
// Shared event codes, roles, send kinds and table types.
// ============================================================================
package tpt_pkg;

	typedef enum logic [2:0] {
		EV_TICK   = 3'd0,
		EV_PACKET = 3'd1,
		EV_CREATE = 3'd2,
		EV_JOIN   = 3'd3,
		EV_LEAVE  = 3'd4,
		EV_SILENCE = 3'd5,
		EV_SCAN   = 3'd6,
		EV_READ   = 3'd7
	} event_t;

	localparam logic [1:0] ROLE_NONE   = 2'd0;
	localparam logic [1:0] ROLE_LEADER = 2'd1;
	localparam logic [1:0] ROLE_MEMBER = 2'd2;

	localparam logic [1:0] SEND_NONE   = 2'd0;
	localparam logic [1:0] SEND_BEACON = 2'd1;
	localparam logic [1:0] SEND_JOIN   = 2'd2;

	localparam logic [7:0] ACT_BEACON  = 8'h42;
	localparam logic [7:0] MIN_PAYLOAD = 8'd9;

	localparam logic [2:0] REG_OWN_NODE = 3'd0;
	localparam logic [2:0] REG_INTERVAL = 3'd1;
	localparam logic [2:0] REG_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_STALE    = 3'd3;
	localparam logic [2:0] REG_SCAN_LEN = 3'd4;

	// one discovered-team record
	typedef struct packed {
		logic [31:0] team;
		logic [31:0] leader;
		logic [31:0] seen;
	} entry_t;

	// configuration set handed to the controller
	typedef struct packed {
		logic [31:0] own_node;
		logic [31:0] interval;
		logic [31:0] timeout;
		logic [31:0] stale;
		logic [31:0] scan_len;
	} cfg_t;

endpackage

>>> rtl/tpt_regs.sv
// ============================================================================
// Team presence tracker register file
// APB-style write/read port for the five configuration registers.
// ============================================================================
module tpt_regs import tpt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	logic       wr;
	logic [2:0] idx;

	assign wr  = psel & penable & pwrite;
	assign idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.own_node <= 32'd0;
			cfg.interval <= 32'd15000;
			cfg.timeout  <= 32'd120000;
			cfg.stale    <= 32'd60000;
			cfg.scan_len <= 32'd60000;
		end else if (wr) begin
			case (idx)
				REG_OWN_NODE: cfg.own_node <= pwdata;
				REG_INTERVAL: cfg.interval <= pwdata;
				REG_TIMEOUT:  cfg.timeout  <= pwdata;
				REG_STALE:    cfg.stale    <= pwdata;
				REG_SCAN_LEN: cfg.scan_len <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_OWN_NODE: prdata = cfg.own_node;
			REG_INTERVAL: prdata = cfg.interval;
			REG_TIMEOUT:  prdata = cfg.timeout;
			REG_STALE:    prdata = cfg.stale;
			REG_SCAN_LEN: prdata = cfg.scan_len;
			default:      prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/tpt_table.sv
// ============================================================================
// Team presence tracker table memory
// Synchronous one-read, one-write store of discovered-team records.
// ============================================================================
module tpt_table import tpt_pkg::*; #(
	parameter int AW = 4,
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/team_presence_tracker.sv
// ============================================================================
// Team presence tracker
// Role, beacon timing and discovered-team table for one node.
// ============================================================================
// Events are taken one at a time. Events that do not touch the table go
// straight from the walk step to the finish and output steps; a slot read is
// a single memory read and takes the same short path. A tick while unjoined
// (ageing) and a beacon while unjoined (search) walk the table memory, one
// entry a cycle through its single read port.
// Clearing the table is instant (per-entry valid flops). The result sits in
// an output register; a new event is accepted once the result is taken.
module team_presence_tracker import tpt_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: mode[2:0], now_ms, team_id, node_num, action, payload_len,
	//          rssi[8:0], snr[7:0], slot[3:0] (low bit up)
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,
	// m_tdata: role, send_kind, msg_team_id, msg_node, alert_tone,
	//          disconnected, scanning, team_count, beacon_rssi, beacon_snr,
	//          slot_valid, beacon_age_ms (low bit up), zero padded
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_FINISH, ST_OUT} state_t;

	cfg_t cfg;
	assign pready = 1'b1;

	tpt_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.cfg(cfg)
	);

	// input fields
	logic [2:0]  f_mode;
	logic [31:0] f_now, f_team, f_node;
	logic [7:0]  f_act, f_len, f_snr;
	logic [8:0]  f_rssi;
	logic [3:0]  f_slot;
	assign f_mode = s_tdata[2:0];
	assign f_now  = s_tdata[34:3];
	assign f_team = s_tdata[66:35];
	assign f_node = s_tdata[98:67];
	assign f_act  = s_tdata[106:99];
	assign f_len  = s_tdata[114:107];
	assign f_rssi = s_tdata[123:115];
	assign f_snr  = s_tdata[131:124];
	assign f_slot = s_tdata[135:132];

	state_t      state_q;
	event_t      mode_q;
	logic [31:0] now_q, team_q, node_q;
	logic [7:0]  act_q, len_q, snr_q;
	logic [8:0]  rssi_q;
	logic [3:0]  slot_q;

	logic [1:0]  role_q;
	logic [31:0] my_team_q, leader_q, last_bcn_q, last_send_q, scan_start_q;
	logic        known_q, due_q, lost_q, silenced_q, scan_q;
	logic [8:0]  held_rssi_q;
	logic [7:0]  held_snr_q;
	logic [TABLE_ENTRIES-1:0] valid_q;

	// walk control
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] cmp_idx_s1;
	logic          cmp_vld_s1;
	logic          hit_q;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;

	// memory ports
	logic   we;
	logic [AW-1:0] waddr;
	entry_t wdata, rdata;
	logic [AW-1:0] raddr;

	assign raddr = rd_idx_q[AW-1:0];

	tpt_table #(.AW(AW), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic is_beacon;
	assign is_beacon = (len_q >= MIN_PAYLOAD) && (act_q == ACT_BEACON);

	logic walk_mode;
	assign walk_mode = (mode_q == EV_TICK && role_q == ROLE_NONE)
		|| (mode_q == EV_PACKET && is_beacon && role_q == ROLE_NONE);

	// compare stage on the returned record
	logic cmp_hit, cmp_stale;
	assign cmp_hit   = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rdata.team == team_q);
	assign cmp_stale = cmp_vld_s1 && valid_q[cmp_idx_s1]
		&& ((now_q - rdata.seen) > cfg.stale);

	// memory write selection
	always_comb begin
		we    = 1'b0;
		waddr = cmp_idx_s1;
		wdata.team   = team_q;
		wdata.leader = node_q;
		wdata.seen   = now_q;
		if (state_q == ST_WALK && mode_q == EV_PACKET && cmp_hit && !hit_q)
			we = 1'b1;
		else if (state_q == ST_FINISH && mode_q == EV_PACKET && !hit_q && free_found_q) begin
			we = 1'b1;
			waddr = free_idx_q;
		end
	end

	logic [CW-1:0] count;
	always_comb begin
		count = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			count = count + CW'(valid_q[i]);
	end

	logic [4:0] count5;
	assign count5 = 5'(count);

	logic [1:0]  o_send;
	logic [31:0] o_team, o_node;
	logic        o_tone, o_svalid;
	logic [4:0]  o_count;
	logic [31:0] o_age;

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;

	// event sequencer with state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= EV_TICK;
			role_q <= ROLE_NONE; my_team_q <= '0; leader_q <= '0;
			last_bcn_q <= '0; last_send_q <= '0; scan_start_q <= '0;
			known_q <= 1'b0; due_q <= 1'b0; lost_q <= 1'b0;
			silenced_q <= 1'b0; scan_q <= 1'b0;
			held_rssi_q <= '0; held_snr_q <= '0;
			valid_q <= '0;
			rd_idx_q <= '0; cmp_idx_s1 <= '0; cmp_vld_s1 <= 1'b0;
			hit_q <= 1'b0; free_found_q <= 1'b0; free_idx_q <= '0;
			m_tvalid <= 1'b0;
			o_send <= SEND_NONE; o_team <= '0; o_node <= '0;
			o_tone <= 1'b0; o_svalid <= 1'b0; o_count <= '0; o_age <= '0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						mode_q <= event_t'(f_mode);
						now_q <= f_now; team_q <= f_team; node_q <= f_node;
						act_q <= f_act; len_q <= f_len; rssi_q <= f_rssi;
						snr_q <= f_snr; slot_q <= f_slot;
						// a slot read presets its address so the record lands early
						rd_idx_q <= (event_t'(f_mode) == EV_READ) ? CW'(f_slot) : '0;
						cmp_vld_s1 <= 1'b0;
						hit_q <= 1'b0; free_found_q <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// issue reads while walking, compare each record in the cycle after its read
					if (walk_mode && rd_idx_q < CW'(TABLE_ENTRIES)) begin
						cmp_idx_s1 <= rd_idx_q[AW-1:0];
						cmp_vld_s1 <= 1'b1;
						rd_idx_q <= rd_idx_q + 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (mode_q == EV_TICK && cmp_stale)
						valid_q[cmp_idx_s1] <= 1'b0;
					if (mode_q == EV_PACKET && cmp_vld_s1) begin
						if (cmp_hit)
							hit_q <= 1'b1;
						if (!valid_q[cmp_idx_s1] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
					end
					if (!(walk_mode && rd_idx_q < CW'(TABLE_ENTRIES)) && !cmp_vld_s1)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					o_send <= SEND_NONE; o_team <= '0; o_node <= '0;
					o_tone <= 1'b0; o_svalid <= 1'b0;
					case (mode_q)
						EV_TICK: begin
							if (role_q == ROLE_LEADER) begin
								if (due_q || (now_q - last_send_q) >= cfg.interval) begin
									o_send <= SEND_BEACON; o_team <= my_team_q;
									o_node <= leader_q; last_send_q <= now_q;
									due_q <= 1'b0;
								end
							end else if (role_q == ROLE_MEMBER) begin
								if (known_q && (now_q - last_bcn_q) > cfg.timeout) begin
									lost_q <= 1'b1;
									if (!lost_q) silenced_q <= 1'b0;
									o_tone <= !lost_q || !silenced_q;
								end
							end else if (scan_q && (now_q - scan_start_q) >= cfg.scan_len) begin
								scan_q <= 1'b0;
							end
						end
						EV_PACKET: begin
							if (is_beacon && role_q == ROLE_NONE && !hit_q && free_found_q)
								valid_q[free_idx_q] <= 1'b1;
							if (is_beacon && role_q == ROLE_MEMBER && team_q == my_team_q) begin
								last_bcn_q <= now_q; known_q <= 1'b1;
								held_rssi_q <= rssi_q; held_snr_q <= snr_q;
								lost_q <= 1'b0;
								if (lost_q) silenced_q <= 1'b0;
							end
						end
						EV_CREATE: begin
							my_team_q <= team_q; leader_q <= cfg.own_node;
							role_q <= ROLE_LEADER; lost_q <= 1'b0; silenced_q <= 1'b0;
							last_send_q <= '0; due_q <= 1'b1; valid_q <= '0;
						end
						EV_JOIN: begin
							my_team_q <= team_q; leader_q <= node_q; role_q <= ROLE_MEMBER;
							last_bcn_q <= now_q; known_q <= 1'b1;
							lost_q <= 1'b0; silenced_q <= 1'b0; valid_q <= '0;
							o_send <= SEND_JOIN; o_team <= team_q; o_node <= cfg.own_node;
						end
						EV_LEAVE: begin
							role_q <= ROLE_NONE; my_team_q <= '0; leader_q <= '0;
							lost_q <= 1'b0; silenced_q <= 1'b0; last_bcn_q <= '0;
							known_q <= 1'b0; last_send_q <= '0; due_q <= 1'b0;
							valid_q <= '0;
						end
						EV_SILENCE: silenced_q <= 1'b1;
						EV_SCAN: begin
							scan_q <= 1'b1; scan_start_q <= now_q; valid_q <= '0;
						end
						default: begin
							// slot read: record already fetched during the walk step
						end
					endcase
					state_q <= ST_OUT;
					rd_idx_q <= '0;
				end
				ST_OUT: begin
					// memory read of the slot has landed
					if (mode_q == EV_READ && {28'd0, slot_q} < 32'(TABLE_ENTRIES)
						&& valid_q[slot_q[AW-1:0]]) begin
						o_svalid <= 1'b1; o_team <= rdata.team; o_node <= rdata.leader;
					end
					o_count <= count5;
					o_age <= known_q ? (now_q - last_bcn_q) : 32'hFFFF_FFFF;
					m_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {2'd0, o_age, o_svalid, held_snr_q, held_rssi_q, o_count,
		scan_q, lost_q, o_tone, o_node, o_team, o_send, role_q};

	// a result is only raised from the final sequencer step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result raised outside output step");
	// no new beat while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");
	// leaders and members keep an empty table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && role_q != ROLE_NONE) |-> valid_q == '0)
		else $error("table populated while joined");

endmodule

>>> sim/tpt_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// Team presence tracker checker
// Watches the config port and both streams, predicts each result beat from
// its own copy of the tracker state and compares it field by field.
// ============================================================================
module tpt_checker import tpt_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending,
	output int           result_count
);

	typedef struct {
		logic [1:0]  role;
		logic [1:0]  send_kind;
		logic [31:0] msg_team;
		logic [31:0] msg_node;
		logic        tone;
		logic        lost;
		logic        scanning;
		logic [4:0]  count;
		logic [8:0]  rssi;
		logic [7:0]  snr;
		logic        slot_valid;
		logic [31:0] age;
	} status_t;

	// configuration copy
	logic [31:0] own_node, interval, timeout, stale, scan_len;

	// tracker state copy
	logic [1:0]  role_now;
	logic [31:0] my_team, leader_id, last_beacon, last_send, scan_start;
	logic        beacon_known, beacon_due, lost_flag, silenced_flag, scan_flag;
	logic [8:0]  held_rssi;
	logic [7:0]  held_snr;
	logic        ent_valid [TABLE_ENTRIES];
	logic [31:0] ent_team [TABLE_ENTRIES];
	logic [31:0] ent_leader [TABLE_ENTRIES];
	logic [31:0] ent_seen [TABLE_ENTRIES];

	status_t expected_status [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			ent_valid[i] = 1'b0;
	endtask

	task automatic reset_tracker();
		own_node = '0; interval = 32'd15000; timeout = 32'd120000;
		stale = 32'd60000; scan_len = 32'd60000;
		role_now = ROLE_NONE; my_team = '0; leader_id = '0;
		last_beacon = '0; last_send = '0; scan_start = '0;
		beacon_known = 0; beacon_due = 0; lost_flag = 0; silenced_flag = 0;
		scan_flag = 0; held_rssi = '0; held_snr = '0;
		clear_table();
	endtask

	// record a beacon heard while unjoined: refresh a known team or take the
	// lowest free slot; a new team is dropped when the table is full
	task automatic log_team(input logic [31:0] team, input logic [31:0] node,
		input logic [31:0] now);
		int free_idx;
		free_idx = -1;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (ent_valid[i] && ent_team[i] == team) begin
				ent_seen[i] = now;
				ent_leader[i] = node;
				return;
			end
			if (!ent_valid[i] && free_idx < 0)
				free_idx = i;
		end
		if (free_idx >= 0) begin
			ent_valid[free_idx] = 1'b1;
			ent_team[free_idx] = team;
			ent_leader[free_idx] = node;
			ent_seen[free_idx] = now;
		end
	endtask

	task automatic track_event(input logic [135:0] beat, output status_t st);
		event_t      ev;
		logic [31:0] now, team, node;
		logic [7:0]  act, plen;
		logic [8:0]  rssi;
		logic [7:0]  snr;
		logic [3:0]  slot;
		ev = event_t'(beat[2:0]);
		now = beat[34:3];
		team = beat[66:35];
		node = beat[98:67];
		act = beat[106:99];
		plen = beat[114:107];
		rssi = beat[123:115];
		snr = beat[131:124];
		slot = beat[135:132];
		st.send_kind = SEND_NONE; st.msg_team = '0; st.msg_node = '0;
		st.tone = 0; st.slot_valid = 0; st.count = '0;
		case (ev)
			EV_TICK: begin
				if (role_now == ROLE_LEADER) begin
					if (beacon_due || (now - last_send) >= interval) begin
						st.send_kind = SEND_BEACON;
						st.msg_team = my_team; st.msg_node = leader_id;
						last_send = now; beacon_due = 0;
					end
				end else if (role_now == ROLE_MEMBER) begin
					if (beacon_known && (now - last_beacon) > timeout) begin
						if (!lost_flag) begin
							lost_flag = 1; silenced_flag = 0;
						end
						if (!silenced_flag)
							st.tone = 1;
					end
				end else begin
					if (scan_flag && (now - scan_start) >= scan_len)
						scan_flag = 0;
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (ent_valid[i] && (now - ent_seen[i]) > stale)
							ent_valid[i] = 1'b0;
				end
			end
			EV_PACKET: begin
				if (plen >= MIN_PAYLOAD && act == ACT_BEACON) begin
					if (role_now == ROLE_NONE)
						log_team(team, node, now);
					if (role_now == ROLE_MEMBER && team == my_team) begin
						last_beacon = now; beacon_known = 1;
						held_rssi = rssi; held_snr = snr;
						if (lost_flag) begin
							lost_flag = 0; silenced_flag = 0;
						end
					end
				end
			end
			EV_CREATE: begin
				my_team = team; leader_id = own_node; role_now = ROLE_LEADER;
				lost_flag = 0; silenced_flag = 0; last_send = '0; beacon_due = 1;
				clear_table();
			end
			EV_JOIN: begin
				my_team = team; leader_id = node; role_now = ROLE_MEMBER;
				last_beacon = now; beacon_known = 1;
				lost_flag = 0; silenced_flag = 0;
				clear_table();
				st.send_kind = SEND_JOIN; st.msg_team = team; st.msg_node = own_node;
			end
			EV_LEAVE: begin
				role_now = ROLE_NONE; my_team = '0; leader_id = '0;
				lost_flag = 0; silenced_flag = 0; last_beacon = '0;
				beacon_known = 0; last_send = '0; beacon_due = 0;
				clear_table();
			end
			EV_SILENCE: silenced_flag = 1;
			EV_SCAN: begin
				scan_flag = 1; scan_start = now;
				clear_table();
			end
			default: begin
				if (slot < TABLE_ENTRIES && ent_valid[slot]) begin
					st.slot_valid = 1;
					st.msg_team = ent_team[slot]; st.msg_node = ent_leader[slot];
				end
			end
		endcase
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (ent_valid[i])
				st.count++;
		st.role = role_now;
		st.lost = lost_flag;
		st.scanning = scan_flag;
		st.rssi = held_rssi;
		st.snr = held_snr;
		st.age = beacon_known ? now - last_beacon : 32'hFFFF_FFFF;
	endtask

	task automatic compare_status(input logic [127:0] beat);
		status_t w;
		if (expected_status.size() == 0) begin
			$display("%0t unexpected result beat %h", $time, beat);
			fail_count++;
			return;
		end
		w = expected_status.pop_front();
		if (beat[1:0] !== w.role) report("role", beat[1:0], w.role);
		if (beat[3:2] !== w.send_kind) report("send_kind", beat[3:2], w.send_kind);
		if (beat[35:4] !== w.msg_team) report("msg_team_id", beat[35:4], w.msg_team);
		if (beat[67:36] !== w.msg_node) report("msg_node", beat[67:36], w.msg_node);
		if (beat[68] !== w.tone) report("alert_tone", beat[68], w.tone);
		if (beat[69] !== w.lost) report("disconnected", beat[69], w.lost);
		if (beat[70] !== w.scanning) report("scanning", beat[70], w.scanning);
		if (beat[75:71] !== w.count) report("team_count", beat[75:71], w.count);
		if (beat[84:76] !== w.rssi) report("beacon_rssi", beat[84:76], w.rssi);
		if (beat[92:85] !== w.snr) report("beacon_snr", beat[92:85], w.snr);
		if (beat[93] !== w.slot_valid) report("slot_valid", beat[93], w.slot_valid);
		if (beat[125:94] !== w.age) report("beacon_age_ms", beat[125:94], w.age);
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		result_count = 0;
		reset_tracker();
	end

	// config writes, event beats and result beats, all sampled at the edge
	always @(posedge clk) begin
		status_t st;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_OWN_NODE: own_node = pwdata;
					REG_INTERVAL: interval = pwdata;
					REG_TIMEOUT:  timeout = pwdata;
					REG_STALE:    stale = pwdata;
					REG_SCAN_LEN: scan_len = pwdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				compare_status(m_tdata);
				result_count++;
			end
			if (s_tvalid && s_tready) begin
				track_event(s_tdata, st);
				expected_status.insert(expected_status.size(), st);
			end
			pending = expected_status.size();
		end
	end

	final_check: assert property (@(posedge clk) 1);

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Team presence tracker testbench
// Drives directed and random event beats through several register settings
// with random gaps on both streams; the checker predicts and compares.
// ============================================================================
module tb import tpt_pkg::*;;

	localparam int LIMIT_CYCLES = 1_500_000;
	localparam int DRAIN_CYCLES = 40;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, m_tvalid, m_tready;
	logic [135:0] s_tdata;
	logic [127:0] m_tdata;
	logic         psel, penable, pwrite, pready;
	logic [4:0]   paddr;
	logic [31:0]  pwdata, prdata;

	int          fail_count, pending, result_count;
	int          cycle_count, sent_count, ready_pct;
	logic [31:0] now_ms, joined_team;
	logic [31:0] team_pool [24];

	team_presence_tracker dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	tpt_checker chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
		.m_tdata, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending, .result_count
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("tb failed");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result side back-pressure
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (ready_pct < 100 && $urandom_range(0, 99) < 3) begin
				hold = $urandom_range(10, 40);
				m_tready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end else
				m_tready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_event(input event_t ev, input logic [31:0] team,
		input logic [31:0] node, input logic [7:0] act, input logic [7:0] plen,
		input logic [8:0] rssi, input logic [7:0] snr, input logic [3:0] slot);
		int gap;
		s_tvalid <= 1;
		s_tdata <= {slot, snr, rssi, plen, act, node, team, now_ms, ev};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_count++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic advance_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) now_ms += $urandom_range(0, 400);
		else if (r < 95) now_ms += $urandom_range(0, 5000);
		else now_ms += $urandom();
	endtask

	task automatic random_event();
		int r;
		logic [31:0] team;
		logic [7:0]  act, plen;
		event_t      ev;
		advance_time();
		r = $urandom_range(0, 99);
		if (r < 30) ev = EV_TICK;
		else if (r < 62) ev = EV_PACKET;
		else if (r < 65) ev = EV_CREATE;
		else if (r < 69) ev = EV_JOIN;
		else if (r < 72) ev = EV_LEAVE;
		else if (r < 77) ev = EV_SILENCE;
		else if (r < 82) ev = EV_SCAN;
		else ev = EV_READ;
		r = $urandom_range(0, 99);
		if (r < 55) team = team_pool[$urandom_range(0, 23)];
		else if (r < 80) team = joined_team;
		else team = $urandom();
		r = $urandom_range(0, 99);
		act = (r < 85) ? ACT_BEACON : (r < 92) ? 8'h4A : 8'($urandom());
		plen = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(9, 255))
			: 8'($urandom_range(0, 8));
		if (ev == EV_JOIN || ev == EV_CREATE) joined_team = team;
		send_event(ev, team, $urandom(), act, plen, 9'(-$urandom_range(0, 200)),
			8'($urandom()), 4'($urandom()));
	endtask

	task automatic configure(input logic [31:0] own, input logic [31:0] ivl,
		input logic [31:0] tmo, input logic [31:0] stl, input logic [31:0] scn);
		reg_write(REG_OWN_NODE, own);
		reg_write(REG_INTERVAL, ivl);
		reg_write(REG_TIMEOUT, tmo);
		reg_write(REG_STALE, stl);
		reg_write(REG_SCAN_LEN, scn);
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		now_ms = '0; sent_count = 0; ready_pct = 100;
		joined_team = 32'h1234_5678;
		foreach (team_pool[i]) team_pool[i] = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: short timings so every timer fires
		configure(32'hFFFF_FFFF, 32'd100, 32'd500, 32'd300, 32'd200);
		now_ms = 32'd10;
		send_event(EV_CREATE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		now_ms += 50;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		now_ms += 100;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_JOIN, 32'hAAAA_5555, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
		now_ms += 10;
		send_event(EV_PACKET, 32'hAAAA_5555, 0, ACT_BEACON, 8'd9, 9'h138, 8'h80, 0);
		now_ms += 600;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_SILENCE, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_PACKET, 32'hAAAA_5555, 0, ACT_BEACON, 8'd255, 9'h000, 8'h7F, 0);
		send_event(EV_LEAVE, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_SCAN, 0, 0, 0, 0, 0, 0, 0);
		send_event(EV_PACKET, 32'h0000_0001, 32'h0BAD_F00D, ACT_BEACON, 8'd9, 9'h1FF, 0, 0);
		send_event(EV_PACKET, 32'h0000_0002, 0, ACT_BEACON, 8'd8, 0, 0, 0);
		send_event(EV_PACKET, 32'h0000_0003, 0, 8'h4A, 8'd20, 0, 0, 0);
		send_event(EV_PACKET, 32'h0000_0004, 0, 8'hFF, 8'd20, 0, 0, 0);
		send_event(EV_READ, 0, 0, 0, 0, 0, 0, 4'd0);
		send_event(EV_READ, 0, 0, 0, 0, 0, 0, 4'd15);
		now_ms += 250;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		now_ms += 400;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		now_ms = 32'hFFFF_FFF0;
		send_event(EV_TICK, 0, 0, 0, 0, 0, 0, 0);
		wait_idle();

		// random phases across settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure($urandom(), 0, 0, 0, 0);
				1: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: configure(32'd0, 32'd15000, 32'd120000, 32'd60000, 32'd60000);
				default: configure($urandom(), $urandom_range(50, 800),
					$urandom_range(200, 3000), $urandom_range(200, 3000),
					$urandom_range(200, 4000));
			endcase
			ready_pct = (ph % 3 == 0) ? 100 : (ph % 3 == 1) ? 70 : 30;
			for (int k = 0; k < 265; k++)
				random_event();
			wait_idle();
		end

		$display("%0d events sent, %0d results checked over 7 register settings",
			sent_count, result_count);
		$display("covered leader, member and unjoined paths with stalls on both sides");
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
